FILE: src/icmpr_pkg.sv
package icmpr_pkg;

  localparam int FRAME_BYTES_DEF = 512;
  localparam int ETH_HDR_BYTES   = 14;
  localparam int REPLY_HDR_BYTES = 34;
  localparam int IP_HDR_BYTES    = 20;
  localparam int IP_SUM_WORDS    = 10;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL     = 8'h45;
  localparam logic [7:0]  IP_TTL         = 8'd128;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [3:0]  IHL_MIN        = 4'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_IPSUM,
    ST_ISRD,
    ST_ISADD,
    ST_ORD,
    ST_ODATA,
    ST_OSEND
  } state_t;

  // Fields of the received header that the reply needs.
  typedef struct packed {
    logic [47:0] smac;
    logic [3:0]  ihl;
    logic [15:0] total;
    logic [7:0]  proto;
    logic [31:0] sip;
    logic [31:0] dip;
  } hdr_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

endpackage

FILE: src/icmpr_rx_if.sv
interface icmpr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rx_last;

  modport source (output valid, output rx_byte, output rx_last, input ready);
  modport sink (input valid, input rx_byte, input rx_last, output ready);
endinterface

FILE: src/icmpr_tx_if.sv
interface icmpr_tx_if;
  logic        valid;
  logic        ready;
  logic [63:0] tx_word;
  logic [3:0]  tx_bytes;
  logic        tx_last;

  modport source (output valid, output tx_word, output tx_bytes, output tx_last, input ready);
  modport sink (input valid, input tx_word, input tx_bytes, input tx_last, output ready);
endinterface

FILE: src/icmp_echo_reply_builder_unit.sv
// Receives an Ethernet/IPv4 frame one byte per cycle into a frame store and, after the last
// byte, answers an ICMP packet with a reply frame delivered as 64-bit words, first wire byte on
// top. Frame bytes are taken one per cycle while the block is idle. After the last byte the block is
// busy: a check state, then the IPv4 header checksum over ten header words, then the ICMP checksum
// with one store read and one pass through the shared 16-bit ones' complement adder per ICMP
// byte, then a read state and an assembly state per reply byte to build the output words, plus a
// hand-over per word that waits for the receiver. A dropped frame ends at the check state. The
// store port is the limit: one byte read per cycle.
module icmp_echo_reply_builder_unit #(
  parameter int FRAME_BYTES = icmpr_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  icmpr_rx_if.sink    rx,
  icmpr_tx_if.source  tx,
  input  logic        cfg_we,
  input  logic [47:0] cfg_data
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int CW = $clog2(FRAME_BYTES + 1);

  logic [47:0]           own_mac;
  logic [CW-1:0]         byte_count;
  logic                  too_long;
  icmpr_pkg::hdr_t       hdr;
  icmpr_pkg::seq_stat_t  stat;
  logic                  rx_fire, store_en;
  logic [AW-1:0]         raddr;
  logic [7:0]            rdata;

  assign rx.ready = stat.idle;
  assign rx_fire  = rx.valid && rx.ready;
  assign store_en = rx_fire && (byte_count < CW'(FRAME_BYTES));

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= '0;
    end else if (cfg_we) begin
      own_mac <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      too_long   <= 1'b0;
    end else if (stat.done) begin
      byte_count <= '0;
      too_long   <= 1'b0;
    end else if (rx_fire) begin
      if (store_en) begin
        byte_count <= byte_count + CW'(1);
      end else begin
        too_long <= 1'b1;
      end
    end
  end

  // Header fields are picked off as they stream past.
  always_ff @(posedge clk) begin
    if (store_en) begin
      for (int j = 0; j < 6; j++) begin
        if (byte_count == CW'(6 + j)) begin
          hdr.smac[47 - 8 * j -: 8] <= rx.rx_byte;
        end
      end
      for (int j = 0; j < 4; j++) begin
        if (byte_count == CW'(26 + j)) begin
          hdr.sip[31 - 8 * j -: 8] <= rx.rx_byte;
        end
        if (byte_count == CW'(30 + j)) begin
          hdr.dip[31 - 8 * j -: 8] <= rx.rx_byte;
        end
      end
      if (byte_count == CW'(14)) begin
        hdr.ihl <= rx.rx_byte[3:0];
      end
      if (byte_count == CW'(16)) begin
        hdr.total[15:8] <= rx.rx_byte;
      end
      if (byte_count == CW'(17)) begin
        hdr.total[7:0] <= rx.rx_byte;
      end
      if (byte_count == CW'(23)) begin
        hdr.proto <= rx.rx_byte;
      end
    end
  end

  icmpr_store #(.DEPTH(FRAME_BYTES), .AW(AW)) u_store (
    .clk   (clk),
    .we    (store_en),
    .waddr (byte_count[AW-1:0]),
    .wdata (rx.rx_byte),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic          seq_start;
  icmpr_pkg::hdr_t hdr_q;
  assign seq_start = rx_fire && rx.rx_last;
  assign hdr_q     = hdr;

  icmpr_ctrl #(.FRAME_BYTES(FRAME_BYTES), .AW(AW), .CW(CW)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (seq_start),
    .hdr        (hdr_q),
    .byte_count (byte_count),
    .too_long   (too_long),
    .own_mac    (own_mac),
    .rdata      (rdata),
    .raddr      (raddr),
    .stat       (stat),
    .tx         (tx)
  );

endmodule

FILE: src/icmpr_store.sv
module icmpr_store #(
  parameter int DEPTH = icmpr_pkg::FRAME_BYTES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/icmpr_csum.sv
module icmpr_csum (
  input  logic        clk,
  input  logic        clr,
  input  logic        add,
  input  logic [15:0] addend,
  output logic [15:0] acc
);

  logic [16:0] sum;

  // End-around carry keeps the running value a folded ones' complement sum.
  assign sum = {1'b0, acc} + {1'b0, addend};

  always_ff @(posedge clk) begin
    if (clr) begin
      acc <= '0;
    end else if (add) begin
      acc <= sum[15:0] + {15'd0, sum[16]};
    end
  end

endmodule

FILE: src/icmpr_ctrl.sv
module icmpr_ctrl #(
  parameter int FRAME_BYTES = icmpr_pkg::FRAME_BYTES_DEF,
  parameter int AW          = $clog2(FRAME_BYTES),
  parameter int CW          = $clog2(FRAME_BYTES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  icmpr_pkg::hdr_t     hdr,
  input  logic [CW-1:0]       byte_count,
  input  logic                too_long,
  input  logic [47:0]         own_mac,
  input  logic [7:0]          rdata,
  output logic [AW-1:0]       raddr,
  output icmpr_pkg::seq_stat_t stat,
  icmpr_tx_if.source          tx
);

  icmpr_pkg::state_t state, state_next;

  logic [3:0]    k;
  logic [CW-1:0] p;
  logic [15:0]   ident;
  logic [15:0]   ip_ck;
  logic [5:0]    ihl4;
  logic [CW-1:0] msg_len;
  logic [CW-1:0] rlen;
  logic [63:0]   word;

  logic          drop;
  logic [5:0]    ihl4_c;
  logic [CW-1:0] msg_len_c;
  logic [15:0]   len16;
  logic [15:0]   ip_word;
  logic          cs_clr, cs_add;
  logic [15:0]   cs_addend, acc, icmp_ck;
  logic [CW-1:0] rd_idx, raddr_w, icmp_i;
  logic [271:0]  hdr_vec;
  logic [5:0]    p6;
  logic [7:0]    out_byte;
  logic [2:0]    slot;
  logic          last_b, send_ok, load;

  icmpr_csum u_csum (
    .clk    (clk),
    .clr    (cs_clr),
    .add    (cs_add),
    .addend (cs_addend),
    .acc    (acc)
  );

  assign ihl4_c    = {hdr.ihl, 2'b00};
  assign msg_len_c = CW'(hdr.total - {10'd0, ihl4_c});
  assign drop = too_long
             || (byte_count < CW'(icmpr_pkg::REPLY_HDR_BYTES))
             || (hdr.ihl < icmpr_pkg::IHL_MIN)
             || (hdr.proto != icmpr_pkg::PROTO_ICMP)
             || ((17'(icmpr_pkg::ETH_HDR_BYTES) + {1'b0, hdr.total}) > 17'(byte_count))
             || ({1'b0, hdr.total} < (17'(ihl4_c) + 17'd4));

  assign len16   = 16'(icmpr_pkg::IP_HDR_BYTES) + 16'(msg_len);
  assign icmp_ck = ~acc;

  always_comb begin
    case (k)
      4'd0:    ip_word = {icmpr_pkg::IP_VER_IHL, 8'h00};
      4'd1:    ip_word = len16;
      4'd2:    ip_word = ident;
      4'd4:    ip_word = {icmpr_pkg::IP_TTL, icmpr_pkg::PROTO_ICMP};
      4'd6:    ip_word = hdr.dip[31:16];
      4'd7:    ip_word = hdr.dip[15:0];
      4'd8:    ip_word = hdr.sip[31:16];
      4'd9:    ip_word = hdr.sip[15:0];
      default: ip_word = 16'h0000;
    endcase
  end

  // In the output pass p counts reply bytes; ICMP data starts after the fixed headers.
  assign icmp_i  = p - CW'(icmpr_pkg::REPLY_HDR_BYTES);
  assign rd_idx  = (state == icmpr_pkg::ST_ORD) ? icmp_i : p;
  assign raddr_w = CW'(icmpr_pkg::ETH_HDR_BYTES) + CW'(ihl4) + rd_idx;
  assign raddr   = raddr_w[AW-1:0];

  assign hdr_vec = {hdr.smac, own_mac, icmpr_pkg::ETHERTYPE_IPV4, icmpr_pkg::IP_VER_IHL, 8'h00,
                    len16, ident, 16'h0000, icmpr_pkg::IP_TTL, icmpr_pkg::PROTO_ICMP, ip_ck,
                    hdr.dip, hdr.sip};
  assign p6   = p[5:0];
  assign slot = p[2:0];

  always_comb begin
    if (p < CW'(icmpr_pkg::REPLY_HDR_BYTES)) begin
      out_byte = hdr_vec[(6'd33 - p6) * 8 +: 8];
    end else if (icmp_i == CW'(0)) begin
      out_byte = 8'h00;
    end else if (icmp_i == CW'(2)) begin
      out_byte = icmp_ck[15:8];
    end else if (icmp_i == CW'(3)) begin
      out_byte = icmp_ck[7:0];
    end else begin
      out_byte = rdata;
    end
  end

  assign last_b  = (p == rlen - CW'(1));
  assign send_ok = !tx.valid || tx.ready;
  assign load    = (state == icmpr_pkg::ST_OSEND) && send_ok;

  always_comb begin
    state_next = state;
    cs_clr     = 1'b0;
    cs_add     = 1'b0;
    cs_addend  = ip_word;
    stat.done  = 1'b0;
    stat.idle  = (state == icmpr_pkg::ST_IDLE);
    unique case (state)
      icmpr_pkg::ST_IDLE: begin
        // The sequencer leaves IDLE on the edge that takes the last frame byte.
        if (start) begin
          state_next = icmpr_pkg::ST_CHECK;
        end
      end
      icmpr_pkg::ST_CHECK: begin
        cs_clr = 1'b1;
        if (drop) begin
          stat.done  = 1'b1;
          state_next = icmpr_pkg::ST_IDLE;
        end else begin
          state_next = icmpr_pkg::ST_IPSUM;
        end
      end
      icmpr_pkg::ST_IPSUM: begin
        cs_add = 1'b1;
        if (k == 4'(icmpr_pkg::IP_SUM_WORDS - 1)) begin
          state_next = icmpr_pkg::ST_ISRD;
        end
      end
      icmpr_pkg::ST_ISRD: begin
        cs_clr     = (p == '0);
        state_next = icmpr_pkg::ST_ISADD;
      end
      icmpr_pkg::ST_ISADD: begin
        // Type and the old checksum count as zero; even offsets are high bytes.
        cs_add = 1'b1;
        if (p == CW'(0) || p == CW'(2) || p == CW'(3)) begin
          cs_addend = 16'h0000;
        end else if (p[0] == 1'b0) begin
          cs_addend = {rdata, 8'h00};
        end else begin
          cs_addend = {8'h00, rdata};
        end
        if (p == msg_len - CW'(1)) begin
          state_next = icmpr_pkg::ST_ORD;
        end else begin
          state_next = icmpr_pkg::ST_ISRD;
        end
      end
      icmpr_pkg::ST_ORD: begin
        state_next = icmpr_pkg::ST_ODATA;
      end
      icmpr_pkg::ST_ODATA: begin
        if (slot == 3'd7 || last_b) begin
          state_next = icmpr_pkg::ST_OSEND;
        end else begin
          state_next = icmpr_pkg::ST_ORD;
        end
      end
      icmpr_pkg::ST_OSEND: begin
        if (send_ok) begin
          if (last_b) begin
            stat.done  = 1'b1;
            state_next = icmpr_pkg::ST_IDLE;
          end else begin
            state_next = icmpr_pkg::ST_ORD;
          end
        end
      end
      default: state_next = icmpr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= icmpr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ident    <= '0;
      tx.valid <= 1'b0;
    end else begin
      if (load) begin
        tx.valid <= 1'b1;
        if (last_b) begin
          ident <= ident + 16'd1;
        end
      end else if (tx.ready) begin
        tx.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      icmpr_pkg::ST_CHECK: begin
        ihl4    <= ihl4_c;
        msg_len <= msg_len_c;
        rlen    <= CW'(icmpr_pkg::REPLY_HDR_BYTES) + msg_len_c;
        k       <= '0;
        word    <= '0;
      end
      icmpr_pkg::ST_IPSUM: begin
        k <= k + 4'd1;
        p <= '0;
      end
      icmpr_pkg::ST_ISRD: begin
        if (p == '0) begin
          ip_ck <= ~acc;
        end
      end
      icmpr_pkg::ST_ISADD: begin
        if (p == msg_len - CW'(1)) begin
          p <= '0;
        end else begin
          p <= p + CW'(1);
        end
      end
      icmpr_pkg::ST_ODATA: begin
        word[(3'd7 - slot) * 8 +: 8] <= out_byte;
        if (!(slot == 3'd7 || last_b)) begin
          p <= p + CW'(1);
        end
      end
      icmpr_pkg::ST_OSEND: begin
        if (send_ok) begin
          tx.tx_word  <= word;
          tx.tx_bytes <= {1'b0, slot} + 4'd1;
          tx.tx_last  <= last_b;
          word        <= '0;
          p           <= p + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (state == icmpr_pkg::ST_CHECK || state == icmpr_pkg::ST_OSEND))
    else $error("frame end signaled outside check or final send");

  a_p_range: assert property (@(posedge clk) disable iff (rst)
    (state == icmpr_pkg::ST_ODATA) |-> (p < rlen))
    else $error("output byte index beyond reply length");

  a_ident: assert property (@(posedge clk) disable iff (rst)
    (ident != $past(ident)) |-> $past(load && last_b))
    else $error("identification changed without a finished reply");

endmodule

FILE: dv/icmpr_tb_pkg.sv
package icmpr_tb_pkg;

  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } reply_word_t;

  class reply_scoreboard;
    logic [7:0]  frame_buf[512];
    int          nstored;
    bit          overflow;
    logic [15:0] ident;
    logic [47:0] mac;
    reply_word_t pending[$];

    function new();
      nstored = 0;
      overflow = 0;
      ident = 0;
      mac = 0;
    endfunction

    function automatic logic [15:0] ones_csum(logic [7:0] b[], int len);
      logic [31:0] sum;
      int i;
      sum = 0;
      for (i = 0; i + 1 < len; i += 2) sum += {b[i], b[i+1]};
      if (i < len) sum += {b[i], 8'h00};
      while (sum > 32'hffff) sum = (sum & 32'hffff) + (sum >> 16);
      return ~sum[15:0];
    endfunction

    function void build_reply();
      int ihl, total, ilen, rlen, i, nw, n;
      logic [7:0] r[];
      logic [7:0] h[];
      logic [7:0] m[];
      logic [15:0] ck;
      reply_word_t w;
      if (overflow || nstored < 34) return;
      ihl = frame_buf[14][3:0] * 4;
      total = {frame_buf[16], frame_buf[17]};
      if (ihl < 20 || frame_buf[23] != 8'd1) return;
      if (14 + total > nstored || total < ihl + 4) return;
      ilen = total - ihl;
      rlen = 34 + ilen;
      r = new[rlen];
      for (i = 0; i < 6; i++) begin
        r[i] = frame_buf[6+i];
        r[6+i] = mac[47-8*i -: 8];
      end
      r[12] = 8'h08; r[13] = 8'h00; r[14] = 8'h45; r[15] = 8'h00;
      r[16] = 8'((20 + ilen) >> 8); r[17] = 8'(20 + ilen);
      r[18] = ident[15:8]; r[19] = ident[7:0];
      r[20] = 8'h00; r[21] = 8'h00; r[22] = 8'd128; r[23] = 8'd1;
      r[24] = 8'h00; r[25] = 8'h00;
      for (i = 0; i < 4; i++) begin
        r[26+i] = frame_buf[30+i];
        r[30+i] = frame_buf[26+i];
      end
      h = new[20];
      for (i = 0; i < 20; i++) h[i] = r[14+i];
      ck = ones_csum(h, 20);
      r[24] = ck[15:8]; r[25] = ck[7:0];
      for (i = 0; i < ilen; i++) r[34+i] = frame_buf[(14+ihl+i) & 511];
      r[34] = 8'h00; r[36] = 8'h00; r[37] = 8'h00;
      m = new[ilen];
      for (i = 0; i < ilen; i++) m[i] = r[34+i];
      ck = ones_csum(m, ilen);
      r[36] = ck[15:8]; r[37] = ck[7:0];
      ident++;
      nw = (rlen + 7) / 8;
      for (i = 0; i < nw; i++) begin
        n = rlen - 8*i;
        if (n > 8) n = 8;
        w.word = 0;
        for (int b = 0; b < n; b++) w.word[63-8*b -: 8] = r[8*i+b];
        w.nbytes = 4'(n);
        w.last = (i == nw - 1);
        pending.push_back(w);
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      if (nstored < 512) begin
        frame_buf[nstored] = b;
        nstored++;
      end else begin
        overflow = 1;
      end
      if (last) begin
        build_reply();
        nstored = 0;
        overflow = 0;
      end
    endfunction

    function bit check_word(logic [63:0] word, logic [3:0] nbytes, logic last,
                            output string msg);
      reply_word_t e;
      msg = "";
      if (pending.size() == 0) begin
        msg = $sformatf("unexpected reply word %h", word);
        return 0;
      end
      e = pending.pop_front();
      if (e.word !== word || e.nbytes !== nbytes || e.last !== last) begin
        msg = $sformatf("reply word got %h/%0d/%b exp %h/%0d/%b",
                        word, nbytes, last, e.word, e.nbytes, e.last);
        return 0;
      end
      return 1;
    endfunction
  endclass

endpackage

FILE: dv/icmp_echo_reply_builder_unit_tb.sv
module icmp_echo_reply_builder_unit_tb;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [47:0] cfg_data = 0;
  bit stall_long = 0;
  bit no_idle = 0;
  int mismatches = 0;
  icmpr_tb_pkg::reply_scoreboard sb;

  icmpr_rx_if rx ();
  icmpr_tx_if tx ();

  icmp_echo_reply_builder_unit uut (
    .clk(clk), .rst(rst), .rx(rx.sink), .tx(tx.source),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%s", msg);
    mismatches++;
  endtask

  // Sink side: random back-pressure, plus one long hold-off on request.
  always @(posedge clk) begin
    string msg;
    if (rst) begin
      tx.ready <= 0;
    end else begin
      if (tx.valid && tx.ready) begin
        if (!sb.check_word(tx.tx_word, tx.tx_bytes, tx.tx_last, msg)) report_mismatch(msg);
      end
      if (stall_long) tx.ready <= 0;
      else tx.ready <= no_idle || ($urandom_range(99) >= 29);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!no_idle && $urandom_range(99) < 29) begin
      rx.valid <= 0;
      @(posedge clk);
    end
    rx.valid <= 1;
    rx.rx_byte <= b;
    rx.rx_last <= last;
    do @(posedge clk); while (!rx.ready);
    sb.note_byte(b, last);
  endtask

  task automatic send_frame(input logic [7:0] f[]);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  task automatic stop_requests();
    rx.valid <= 0;
    @(posedge clk);
  endtask

  // Builds an IPv4 frame with random contents; ihl_w, pay_len, trail and proto select the shape.
  task automatic make_icmp(output logic [7:0] f[], input int ihl_w, input int pay_len,
                           input int trail, input logic [7:0] proto);
    int tot, n;
    tot = ihl_w * 4 + pay_len;
    n = 14 + tot + trail;
    if (n < 1) n = 1;
    f = new[n];
    foreach (f[i]) f[i] = 8'($urandom);
    if (n > 23) begin
      f[14] = {4'h4, ihl_w[3:0]};
      f[16] = 8'(tot >> 8);
      f[17] = 8'(tot);
      f[23] = proto;
    end
  endtask

  task automatic drain();
    stop_requests();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task automatic write_mac(input logic [47:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_data <= v;
    sb.mac = v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    logic [7:0] f[];
    sb = new();
    rx.valid = 0;
    rx.rx_byte = 0;
    rx.rx_last = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_mac(48'hffffffffffff);
    // The first two requests arrive with no gaps at all.
    no_idle = 1;
    make_icmp(f, 5, 4, 0, 8'd1); send_frame(f);
    make_icmp(f, 5, 5, 3, 8'd1); send_frame(f);
    no_idle = 0;
    make_icmp(f, 6, 9, 0, 8'd1); send_frame(f);
    make_icmp(f, 5, 3, 0, 8'd1); send_frame(f);
    make_icmp(f, 4, 6, 0, 8'd1); send_frame(f);
    make_icmp(f, 5, 6, 0, 8'd6); send_frame(f);
    make_icmp(f, 5, 6, 0, 8'd1); f[17] = f[17] + 8'd1; send_frame(f);
    f = new[20];
    foreach (f[i]) f[i] = 8'($urandom);
    send_frame(f);
    drain();
    write_mac(48'({$urandom, $urandom}));
    // Long receiver hold-off while requests keep arriving.
    fork
      begin
        stall_long = 1;
        repeat (3000) @(posedge clk);
        stall_long = 0;
      end
      begin
        for (int k = 0; k < 2; k++) begin
          make_icmp(f, 5, 4 + k * 9, 0, 8'd1);
          send_frame(f);
        end
        stop_requests();
      end
    join
    drain();
    if (mismatches == 0) $display("icmp_echo_reply_builder_unit: match");
    else $display("icmp_echo_reply_builder_unit: mismatch");
    $finish;
  end

  initial begin
    #20000000;
    $display("icmp_echo_reply_builder_unit: mismatch");
    $finish;
  end

endmodule

FILE: files.f
src/icmpr_pkg.sv
src/icmpr_rx_if.sv
src/icmpr_tx_if.sv
src/icmpr_store.sv
src/icmpr_csum.sv
src/icmpr_ctrl.sv
src/icmp_echo_reply_builder_unit.sv
dv/icmpr_tb_pkg.sv
dv/icmp_echo_reply_builder_unit_tb.sv
